[rtl/core/histogram_bucket_table_core_assert.svh]
// Assertion macros used by the histogram bucket table datapath.
`ifndef HISTOGRAM_BUCKET_TABLE_CORE_ASSERT_SVH
`define HISTOGRAM_BUCKET_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram bucket table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram bucket table assertion failed");

`endif

[rtl/core/hbt_pkg.sv]
package hbt_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DATA_W = 32;
  localparam int DIV_STEPS = 32;
  localparam logic [DATA_W-1:0] INT_MAX_VAL = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_INIT   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [5:0]         entry_index;
    logic               is_last_entry;
    logic signed [31:0] operand_value;
    logic signed [31:0] range_maximum;
    logic [5:0]         bucket_total;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       hit;
    logic [5:0] bin_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREP,
    ST_DIV,
    ST_ZERO,
    ST_MID,
    ST_MAX,
    ST_TOP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic write_entry;
    logic init_prep;
    logic div_step;
    logic init_zero;
    logic mid_step;
    logic init_max;
    logic init_top;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    init_bad;
    logic    div_done;
    logic    mid_done;
    logic    scan_done;
    logic    out_busy;
  } dp_status_t;

endpackage

[rtl/core/hbt_ram.sv]
module hbt_ram #(
  parameter int WIDTH = hbt_pkg::DATA_W,
  parameter int DEPTH = hbt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/hbt_ctrl.sv]
module hbt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbt_pkg::dp_status_t sts_i,
  output hbt_pkg::ctrl_cmd_t  cmd_o
);

  hbt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      hbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = hbt_pkg::ST_DECODE;
        end
      end
      hbt_pkg::ST_DECODE: begin
        unique case (sts_i.op)
          hbt_pkg::OP_WRITE: begin
            cmd_o.write_entry = 1'b1;
            state_nxt         = hbt_pkg::ST_FINISH;
          end
          hbt_pkg::OP_INIT: begin
            state_nxt = sts_i.init_bad ? hbt_pkg::ST_FINISH : hbt_pkg::ST_PREP;
          end
          hbt_pkg::OP_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            state_nxt        = hbt_pkg::ST_SCAN;
          end
          default: begin
            state_nxt = hbt_pkg::ST_FINISH;
          end
        endcase
      end
      hbt_pkg::ST_PREP: begin
        cmd_o.init_prep = 1'b1;
        state_nxt       = hbt_pkg::ST_DIV;
      end
      hbt_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_nxt = hbt_pkg::ST_ZERO;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      hbt_pkg::ST_ZERO: begin
        cmd_o.init_zero = 1'b1;
        state_nxt       = hbt_pkg::ST_MID;
      end
      hbt_pkg::ST_MID: begin
        if (sts_i.mid_done) begin
          state_nxt = hbt_pkg::ST_MAX;
        end else begin
          cmd_o.mid_step = 1'b1;
        end
      end
      hbt_pkg::ST_MAX: begin
        cmd_o.init_max = 1'b1;
        state_nxt      = hbt_pkg::ST_TOP;
      end
      hbt_pkg::ST_TOP: begin
        cmd_o.init_top = 1'b1;
        state_nxt      = hbt_pkg::ST_FINISH;
      end
      hbt_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_nxt = hbt_pkg::ST_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      hbt_pkg::ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = hbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hbt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != hbt_pkg::ST_IDLE);

endmodule

[rtl/core/hbt_datapath.sv]
`include "histogram_bucket_table_core_assert.svh"

module hbt_datapath #(
  parameter int TABLE_DEPTH = hbt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hbt_pkg::in_item_t   in_data,
  input  hbt_pkg::ctrl_cmd_t  cmd_i,
  output hbt_pkg::dp_status_t sts_o,
  input  logic                out_stall,
  output logic                out_valid,
  output hbt_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = hbt_pkg::DATA_W;

  hbt_pkg::in_item_t  item_r;
  hbt_pkg::out_item_t out_r, res;
  logic               out_valid_r;
  logic [EW-1:0]      entries_r, ptr_r, cnt_r;
  logic               pend_r;
  logic [DW-1:0]      div_q_r, acc_q_r;
  logic [5:0]         div_rem_r, div_cnt_r, acc_rem_r, gen_i_r;
  logic               neg_r;

  logic [5:0]    divisor;
  logic [6:0]    trial, rsum;
  logic          trial_ge, wrap;
  logic [DW:0]   diff, abs_diff, qext, qsgn, gen_sum;
  logic          write_bad, init_bad, le, hit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data, rd_data;

  assign divisor  = item_r.bucket_total - 6'd2;
  assign trial    = {div_rem_r, div_q_r[DW-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign rsum     = {1'b0, acc_rem_r} + {1'b0, div_rem_r};
  assign wrap     = (rsum >= {1'b0, divisor});

  assign diff     = {item_r.range_maximum[DW-1], item_r.range_maximum}
                  - {item_r.operand_value[DW-1], item_r.operand_value};
  assign abs_diff = diff[DW] ? (~diff + 1'b1) : diff;
  assign qext     = {1'b0, acc_q_r};
  assign qsgn     = neg_r ? (~qext + 1'b1) : qext;
  assign gen_sum  = {item_r.operand_value[DW-1], item_r.operand_value} + qsgn;

  assign write_bad = (int'(item_r.entry_index) >= TABLE_DEPTH);
  assign init_bad  = (item_r.bucket_total < 6'd2)
                  || (int'(item_r.bucket_total) > TABLE_DEPTH - 1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd_i.write_entry) begin
      wr_en   = !write_bad;
      wr_addr = AW'(item_r.entry_index);
      wr_data = item_r.operand_value;
    end else if (cmd_i.init_zero) begin
      wr_en = 1'b1;
    end else if (cmd_i.mid_step) begin
      wr_en   = 1'b1;
      wr_addr = AW'(gen_i_r);
      wr_data = gen_sum[DW-1:0];
    end else if (cmd_i.init_max) begin
      wr_en   = 1'b1;
      wr_addr = AW'(item_r.bucket_total - 6'd1);
      wr_data = item_r.range_maximum;
    end else if (cmd_i.init_top) begin
      wr_en   = 1'b1;
      wr_addr = AW'(item_r.bucket_total);
      wr_data = hbt_pkg::INT_MAX_VAL;
    end
  end

  hbt_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(ptr_r[AW-1:0]),
    .rd_data(rd_data)
  );

  assign le = ($signed(rd_data) <= item_r.operand_value);

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      item_r <= in_data;
    end
    if (cmd_i.init_prep) begin
      div_q_r   <= abs_diff[DW-1:0];
      neg_r     <= diff[DW];
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd_i.div_step) begin
      div_q_r   <= {div_q_r[DW-2:0], trial_ge};
      div_rem_r <= trial_ge ? 6'(trial - {1'b0, divisor}) : trial[5:0];
      div_cnt_r <= div_cnt_r + 6'd1;
    end
    if (cmd_i.init_zero) begin
      acc_q_r   <= '0;
      acc_rem_r <= '0;
      gen_i_r   <= 6'd1;
    end else if (cmd_i.mid_step) begin
      acc_q_r   <= acc_q_r + div_q_r + DW'(wrap);
      acc_rem_r <= wrap ? 6'(rsum - {1'b0, divisor}) : rsum[5:0];
      gen_i_r   <= gen_i_r + 6'd1;
    end
    if (cmd_i.scan_start) begin
      ptr_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (ptr_r < entries_r) begin
        ptr_r <= ptr_r + EW'(1);
      end
      pend_r <= (ptr_r < entries_r);
      if (pend_r) begin
        cnt_r <= cnt_r + EW'(le);
      end
    end
    if (cmd_i.load_out) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.write_entry && !write_bad && item_r.is_last_entry) begin
        entries_r <= EW'(item_r.entry_index) + EW'(1);
      end else if (cmd_i.init_top) begin
        entries_r <= EW'(item_r.bucket_total) + EW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign hit = (item_r.opcode == hbt_pkg::OP_LOOKUP) && (cnt_r != '0) && (cnt_r < entries_r);

  always_comb begin
    res.status = ((item_r.opcode == hbt_pkg::OP_WRITE) && write_bad)
              || ((item_r.opcode == hbt_pkg::OP_INIT) && init_bad)
              || (item_r.opcode == hbt_pkg::OP_UNUSED);
    res.hit       = hit;
    res.bin_index = hit ? 6'(cnt_r - EW'(1)) : 6'd0;
  end

  assign sts_o.op        = item_r.opcode;
  assign sts_o.init_bad  = init_bad;
  assign sts_o.div_done  = (div_cnt_r == 6'(hbt_pkg::DIV_STEPS));
  assign sts_o.mid_done  = (({1'b0, gen_i_r} + 7'd1) >= {1'b0, item_r.bucket_total});
  assign sts_o.scan_done = (ptr_r == entries_r) && !pend_r;
  assign sts_o.out_busy  = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HBT_ASSERT_IMPL(a_scan_bound, clk, rst_n, cmd_i.scan_step, ptr_r <= entries_r)
  `HBT_ASSERT_IMPL(a_div_rem, clk, rst_n, cmd_i.div_step && (divisor != '0), div_rem_r < divisor)
  `HBT_ASSERT_IMPL(a_load_free, clk, rst_n, cmd_i.load_out, !(out_valid_r && out_stall))
  `HBT_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd_i.load_out, out_valid_r)

endmodule

[rtl/core/histogram_bucket_table_core.sv]
// Histogram bucket table: one result transfer for every input transfer, one item
// at a time; the input stalls from acceptance until the result register loads.
// A write-entry, a rejected init or an unused opcode goes straight from decode to
// the result; a lookup waits on the linear scan that reads one table entry per
// cycle through the single registered read port, and an accepted linear init waits
// on the 32-step quotient of the spacing and then one table write per entry. The
// next input can be accepted in the cycle after the result loads; a result still
// held by the receiver keeps the block busy until it moves. The table itself is
// not cleared by reset.
module histogram_bucket_table_core #(
  parameter int TABLE_DEPTH = hbt_pkg::DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hbt_pkg::out_item_t out_data
);

  hbt_pkg::ctrl_cmd_t  cmd;
  hbt_pkg::dp_status_t sts;

  hbt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  hbt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
